FILE: src/assert_macros.svh
// assertion macros used by dh_link_transform_unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/dhlt_pkg.sv
// types, constants and the angle reduction for the dh link transform
// no dependencies
package dhlt_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int AW              = DATA_WIDTH + 1;   // theta plus offset
    localparam int XW              = 27;               // cordic x and y, Q.24
    localparam int ZW              = 27;               // cordic angle, Q.24
    localparam int TRIG_STAGES_DEF = 14;
    localparam int ATAN_COUNT      = 24;

    localparam int PI_Q24      = 52707179;
    localparam int HALF_PI_Q24 = 26353589;
    localparam int TWO_PI_Q24  = 2 * PI_Q24;
    localparam int CORDIC_K    = 10188014;
    localparam int ONE_Q14     = 16384;

    localparam logic JOINT_REVOLUTE = 1'b0;

    localparam int ATAN_Q24 [ATAN_COUNT] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    // payload travelling along the cordic chain
    typedef struct packed {
        lane_t th;
        lane_t al;
        logic  th_neg;
        logic  al_neg;
        data_t la;
        data_t deff;
    } cord_t;

    typedef struct packed {
        data_t r00;
        data_t r01;
        data_t r02;
        data_t tx;
        data_t r10;
        data_t r11;
        data_t r12;
        data_t ty;
        data_t r20;
        data_t r21;
        data_t r22;
        data_t tz;
    } res_t;

    // Q5.12 angle to Q.24 in (-pi, pi]
    function automatic logic signed [ZW-1:0] reduce_angle(input logic signed [AW-1:0] ang);
        logic signed [31:0] z;
        logic signed [31:0] c;
        logic signed [ZW-1:0] r;
        z = {{(32-AW-12){ang[AW-1]}}, ang, 12'b0};
        r = '0;
        for (int k = -3; k <= 3; k++) begin
            c = z + 32'(k * TWO_PI_Q24);
            if (c > -PI_Q24 && c <= PI_Q24) begin
                r = c[ZW-1:0];
            end
        end
        return r;
    endfunction

endpackage

FILE: src/dhlt_front.sv
// front end: joint select, angle reduction and quadrant fold
// depends on dhlt_pkg
module dhlt_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         joint_type,
    input  dhlt_pkg::data_t              joint_value,
    input  dhlt_pkg::data_t              link_d,
    input  dhlt_pkg::data_t              link_a,
    input  dhlt_pkg::data_t              link_alpha,
    input  dhlt_pkg::data_t              link_offset,
    output logic                         out_valid,
    output dhlt_pkg::cord_t              out_data
);

    localparam int AW = dhlt_pkg::AW;
    localparam int ZW = dhlt_pkg::ZW;
    localparam int XW = dhlt_pkg::XW;

    logic [2:0]                v_reg;
    logic signed [AW-1:0]      th_reg, al_reg;
    logic signed [ZW-1:0]      thr_reg, alr_reg;
    dhlt_pkg::data_t           la1_reg, d1_reg, la2_reg, d2_reg;
    dhlt_pkg::cord_t           o_reg;
    logic signed [AW-1:0]      th_next;
    dhlt_pkg::cord_t           o_next;
    logic signed [ZW-1:0]      thf, alf;
    logic                      thn, aln;

    assign th_next = (joint_type == dhlt_pkg::JOINT_REVOLUTE)
                   ? (AW'(joint_value) + AW'(link_offset)) : AW'(link_offset);

    // fold into the half plane the cordic covers
    always_comb begin
        thf = thr_reg;
        thn = 1'b0;
        if (thr_reg > dhlt_pkg::HALF_PI_Q24) begin
            thf = thr_reg - ZW'(dhlt_pkg::PI_Q24);
            thn = 1'b1;
        end else if (thr_reg < -dhlt_pkg::HALF_PI_Q24) begin
            thf = thr_reg + ZW'(dhlt_pkg::PI_Q24);
            thn = 1'b1;
        end
        alf = alr_reg;
        aln = 1'b0;
        if (alr_reg > dhlt_pkg::HALF_PI_Q24) begin
            alf = alr_reg - ZW'(dhlt_pkg::PI_Q24);
            aln = 1'b1;
        end else if (alr_reg < -dhlt_pkg::HALF_PI_Q24) begin
            alf = alr_reg + ZW'(dhlt_pkg::PI_Q24);
            aln = 1'b1;
        end
        o_next.th.x   = XW'(dhlt_pkg::CORDIC_K);
        o_next.th.y   = '0;
        o_next.th.z   = thf;
        o_next.al.x   = XW'(dhlt_pkg::CORDIC_K);
        o_next.al.y   = '0;
        o_next.al.z   = alf;
        o_next.th_neg = thn;
        o_next.al_neg = aln;
        o_next.la     = la2_reg;
        o_next.deff   = d2_reg;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            th_reg  <= th_next;
            al_reg  <= AW'(link_alpha);
            la1_reg <= link_a;
            d1_reg  <= (joint_type == dhlt_pkg::JOINT_REVOLUTE) ? link_d : joint_value;
            thr_reg <= dhlt_pkg::reduce_angle(th_reg);
            alr_reg <= dhlt_pkg::reduce_angle(al_reg);
            la2_reg <= la1_reg;
            d2_reg  <= d1_reg;
            o_reg   <= o_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = o_reg;

endmodule

FILE: src/dhlt_cordic_cell.sv
// one cordic rotation cell, both angles side by side
// depends on dhlt_pkg
module dhlt_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  dhlt_pkg::cord_t in_data,
    output logic            out_valid,
    output dhlt_pkg::cord_t out_data
);

    localparam int ZW = dhlt_pkg::ZW;
    localparam logic signed [ZW-1:0] ATAN = ZW'(dhlt_pkg::ATAN_Q24[SHIFT]);

    logic            v_reg;
    dhlt_pkg::cord_t d_reg;
    dhlt_pkg::cord_t d_next;

    function automatic dhlt_pkg::lane_t rot(input dhlt_pkg::lane_t l);
        dhlt_pkg::lane_t r;
        if (l.z >= 0) begin
            r.x = l.x - (l.y >>> SHIFT);
            r.y = l.y + (l.x >>> SHIFT);
            r.z = l.z - ATAN;
        end else begin
            r.x = l.x + (l.y >>> SHIFT);
            r.y = l.y - (l.x >>> SHIFT);
            r.z = l.z + ATAN;
        end
        return r;
    endfunction

    // rotate both lanes, pass the rest along
    always_comb begin
        d_next    = in_data;
        d_next.th = rot(in_data.th);
        d_next.al = rot(in_data.al);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

FILE: src/dhlt_back.sv
// back end: sine/cosine rounding, matrix products and saturation
// depends on dhlt_pkg
module dhlt_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  dhlt_pkg::cord_t in_data,
    output logic            out_valid,
    output dhlt_pkg::res_t  out_data
);

    localparam int XW = dhlt_pkg::XW;
    localparam int DW = dhlt_pkg::DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int QW = PW - 14;

    logic [2:0]      v_reg;
    dhlt_pkg::data_t ct_reg, st_reg, ca_reg, sa_reg, la_reg, d_reg;
    dhlt_pkg::data_t ct2_reg, st2_reg, ca2_reg, sa2_reg, d2_reg;
    logic signed [PW-1:0] p_cast_reg, p_sast_reg, p_lact_reg;
    logic signed [PW-1:0] p_cact_reg, p_sact_reg, p_last_reg;
    dhlt_pkg::res_t  r_reg;
    dhlt_pkg::res_t  r_next;

    // Q.24 to Q2.14, clamped to one, sign from the fold
    function automatic dhlt_pkg::data_t to_q14(input logic signed [XW-1:0] v, input logic neg);
        logic signed [XW-1:0]  t;
        logic signed [XW-11:0] q;
        logic signed [DW-1:0]  c;
        t = v + XW'(512);
        q = t[XW-1:10];
        if (q > dhlt_pkg::ONE_Q14) begin
            c = DW'(dhlt_pkg::ONE_Q14);
        end else if (q < -dhlt_pkg::ONE_Q14) begin
            c = -DW'(dhlt_pkg::ONE_Q14);
        end else begin
            c = q[DW-1:0];
        end
        return neg ? -c : c;
    endfunction

    function automatic logic signed [QW-1:0] rnd14(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(8192);
        return t[PW-1:14];
    endfunction

    function automatic dhlt_pkg::data_t sat(input logic signed [QW-1:0] q);
        logic signed [QW-1:0] hi, lo;
        hi = QW'((1 << (DW - 1)) - 1);
        lo = -hi - QW'(1);
        if (q > hi) begin
            return hi[DW-1:0];
        end else if (q < lo) begin
            return lo[DW-1:0];
        end
        return q[DW-1:0];
    endfunction

    // final rounding and assembly
    always_comb begin
        logic signed [QW-1:0] q;
        q          = rnd14(p_cast_reg);
        r_next.r01 = -q[DW-1:0];
        q          = rnd14(p_sast_reg);
        r_next.r02 = q[DW-1:0];
        q          = rnd14(p_cact_reg);
        r_next.r11 = q[DW-1:0];
        q          = rnd14(p_sact_reg);
        r_next.r12 = -q[DW-1:0];
        r_next.tx  = sat(rnd14(p_lact_reg));
        r_next.ty  = sat(rnd14(p_last_reg));
        r_next.r00 = ct2_reg;
        r_next.r10 = st2_reg;
        r_next.r20 = '0;
        r_next.r21 = sa2_reg;
        r_next.r22 = ca2_reg;
        r_next.tz  = d2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // rounding stage, product stage, output stage
    always_ff @(posedge aclk) begin
        if (en) begin
            ct_reg     <= to_q14(in_data.th.x, in_data.th_neg);
            st_reg     <= to_q14(in_data.th.y, in_data.th_neg);
            ca_reg     <= to_q14(in_data.al.x, in_data.al_neg);
            sa_reg     <= to_q14(in_data.al.y, in_data.al_neg);
            la_reg     <= in_data.la;
            d_reg      <= in_data.deff;
            p_cast_reg <= ca_reg * st_reg;
            p_sast_reg <= sa_reg * st_reg;
            p_lact_reg <= la_reg * ct_reg;
            p_cact_reg <= ca_reg * ct_reg;
            p_sact_reg <= sa_reg * ct_reg;
            p_last_reg <= la_reg * st_reg;
            ct2_reg    <= ct_reg;
            st2_reg    <= st_reg;
            ca2_reg    <= ca_reg;
            sa2_reg    <= sa_reg;
            d2_reg     <= d_reg;
            r_reg      <= r_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = r_reg;

endmodule

FILE: src/dh_link_transform_unit.sv
// a link passes through the front end, the cordic cell chain, the back end and the output register
// throughput: one link per cycle while the spare register is empty, set by the cordic cell chain, one cell per rotation
// a spare output register takes a result while the output stalls; the pipe then holds
// reset: synchronous active-low aresetn clears all valid bits, no clearing pass
// depends on dhlt_pkg, dhlt_front, dhlt_cordic_cell, dhlt_back, assert_macros.svh
`include "assert_macros.svh"
module dh_link_transform_unit #(
    parameter int TRIG_STAGES = dhlt_pkg::TRIG_STAGES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_joint_type,
    input  dhlt_pkg::data_t s_joint_value,
    input  dhlt_pkg::data_t s_link_d,
    input  dhlt_pkg::data_t s_link_a,
    input  dhlt_pkg::data_t s_link_alpha,
    input  dhlt_pkg::data_t s_link_offset,
    output logic            m_valid,
    input  logic            m_ready,
    output dhlt_pkg::data_t m_r00,
    output dhlt_pkg::data_t m_r01,
    output dhlt_pkg::data_t m_r02,
    output dhlt_pkg::data_t m_tx,
    output dhlt_pkg::data_t m_r10,
    output dhlt_pkg::data_t m_r11,
    output dhlt_pkg::data_t m_r12,
    output dhlt_pkg::data_t m_ty,
    output dhlt_pkg::data_t m_r20,
    output dhlt_pkg::data_t m_r21,
    output dhlt_pkg::data_t m_r22,
    output dhlt_pkg::data_t m_tz
);

    logic            en;
    logic            chain_v [TRIG_STAGES+1];
    dhlt_pkg::cord_t chain_d [TRIG_STAGES+1];
    logic            pv;
    dhlt_pkg::res_t  pd;
    logic            m_valid_reg, sp_valid_reg;
    dhlt_pkg::res_t  m_data_reg, sp_data_reg;

    // the whole pipe moves unless the spare register is occupied
    assign en      = !sp_valid_reg;
    assign s_ready = en;

    dhlt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .joint_type  (s_joint_type),
        .joint_value (s_joint_value),
        .link_d      (s_link_d),
        .link_a      (s_link_a),
        .link_alpha  (s_link_alpha),
        .link_offset (s_link_offset),
        .out_valid   (chain_v[0]),
        .out_data    (chain_d[0])
    );

    // cordic cell chain
    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
        dhlt_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_v[i]),
            .in_data   (chain_d[i]),
            .out_valid (chain_v[i+1]),
            .out_data  (chain_d[i+1])
        );
    end

    dhlt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_v[TRIG_STAGES]),
        .in_data   (chain_d[TRIG_STAGES]),
        .out_valid (pv),
        .out_data  (pd)
    );

    // output register with spare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sp_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (sp_valid_reg) begin
                m_data_reg   <= sp_data_reg;
                m_valid_reg  <= 1'b1;
                sp_valid_reg <= 1'b0;
            end else begin
                m_data_reg  <= pd;
                m_valid_reg <= pv && en;
            end
        end else if (pv && en) begin
            sp_data_reg  <= pd;
            sp_valid_reg <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_r00   = m_data_reg.r00;
    assign m_r01   = m_data_reg.r01;
    assign m_r02   = m_data_reg.r02;
    assign m_tx    = m_data_reg.tx;
    assign m_r10   = m_data_reg.r10;
    assign m_r11   = m_data_reg.r11;
    assign m_r12   = m_data_reg.r12;
    assign m_ty    = m_data_reg.ty;
    assign m_r20   = m_data_reg.r20;
    assign m_r21   = m_data_reg.r21;
    assign m_r22   = m_data_reg.r22;
    assign m_tz    = m_data_reg.tz;

    // checks
    `ASSERT_IMP(a_spare_behind_out, aclk, aresetn, sp_valid_reg, m_valid_reg)
    `ASSERT_NXT(a_spare_kept, aclk, aresetn, sp_valid_reg && !m_ready, sp_valid_reg)
    `ASSERT_IMP(a_cos_range, aclk, aresetn, m_valid, m_r00 <= 16384 && m_r00 >= -16384)

endmodule
